// File: rtl/stim_pkg.sv
// Package for the sorted table: payload structs, operation and status codes, control types.
package stim_pkg;

	localparam int OUT_KEY_W = 64;
	localparam int QTY_W     = 32;
	localparam int POS_OUT_W = 6;
	localparam int CNT_OUT_W = 7;
	localparam int MAX_IDX_W = 10;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] STATUS_STORED = 2'd0;
	localparam logic [1:0] STATUS_MERGED = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;
	localparam logic [1:0] STATUS_RANGE  = 2'd3;

	typedef struct packed {
		logic [1:0]              operation;
		logic [OUT_KEY_W-1:0]    item_key;
		logic signed [QTY_W-1:0] item_quantity;
		logic [5:0]              read_index;
	} stim_in_t;

	typedef struct packed {
		logic [OUT_KEY_W-1:0]    entry_key;
		logic signed [QTY_W-1:0] entry_quantity;
		logic [POS_OUT_W-1:0]    entry_position;
		logic [CNT_OUT_W-1:0]    entry_count;
		logic [1:0]              status;
	} stim_out_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_WRITE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [MAX_IDX_W-1:0]   pos;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEARCH,
		ST_FETCH,
		ST_GATHER,
		ST_FINISH
	} stim_state_t;

endpackage

// File: rtl/stim_cell.sv
// One table cell: holds an entry, compares it with the broadcast key and shifts from its left neighbour.
module stim_cell #(
	parameter int KEY_BITS = 64,
	parameter int INDEX    = 0
) (
	input  logic                               clk,
	input  stim_pkg::cell_cmd_t                cmd,
	input  logic [KEY_BITS-1:0]                bcast_key,
	input  logic signed [stim_pkg::QTY_W-1:0]  bcast_qty,
	input  logic [KEY_BITS-1:0]                left_key,
	input  logic signed [stim_pkg::QTY_W-1:0]  left_qty,
	output logic [KEY_BITS-1:0]                key,
	output logic signed [stim_pkg::QTY_W-1:0]  qty,
	output logic                               lt,
	output logic                               eq
);
	import stim_pkg::*;

	logic [KEY_BITS-1:0]     key_q;
	logic signed [QTY_W-1:0] qty_q;
	logic                    lt_q;
	logic                    eq_q;
	logic                    at_pos;
	logic                    above_pos;

	assign at_pos    = (int'(cmd.pos) == INDEX);
	assign above_pos = (int'(cmd.pos) < INDEX);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_CMP: begin
				lt_q <= (key_q < bcast_key);
				eq_q <= (key_q == bcast_key);
			end
			CELL_WRITE: begin
				if (at_pos) begin
					key_q <= bcast_key;
					qty_q <= bcast_qty;
				end
			end
			CELL_SHIFT: begin
				if (at_pos) begin
					key_q <= bcast_key;
					qty_q <= bcast_qty;
				end else if (above_pos) begin
					key_q <= left_key;
					qty_q <= left_qty;
				end
			end
			default: begin
			end
		endcase
	end

	assign key = key_q;
	assign qty = qty_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

// File: rtl/stim_gather.sv
// Two-stage registered OR tree that picks out the entry of one cell by index.
module stim_gather #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 64,
	parameter int IDX_W    = 6
) (
	input  logic                               clk,
	input  logic [KEY_BITS-1:0]                cell_key [CAPACITY],
	input  logic signed [stim_pkg::QTY_W-1:0]  cell_qty [CAPACITY],
	input  logic [IDX_W-1:0]                   target,
	output logic [KEY_BITS-1:0]                rd_key,
	output logic signed [stim_pkg::QTY_W-1:0]  rd_qty
);
	import stim_pkg::*;

	localparam int GROUP   = 8;
	localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

	logic [KEY_BITS-1:0] grp_key_d  [NGROUPS];
	logic [QTY_W-1:0]    grp_qty_d  [NGROUPS];
	logic [KEY_BITS-1:0] grp_key_s1 [NGROUPS];
	logic [QTY_W-1:0]    grp_qty_s1 [NGROUPS];
	logic [KEY_BITS-1:0] all_key_d;
	logic [QTY_W-1:0]    all_qty_d;
	logic [KEY_BITS-1:0] rd_key_s2;
	logic [QTY_W-1:0]    rd_qty_s2;

	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			grp_key_d[g] = '0;
			grp_qty_d[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < CAPACITY) begin
					if (int'(target) == g * GROUP + j) begin
						grp_key_d[g] = grp_key_d[g] | cell_key[g * GROUP + j];
						grp_qty_d[g] = grp_qty_d[g] | cell_qty[g * GROUP + j];
					end
				end
			end
		end
	end

	always_comb begin
		all_key_d = '0;
		all_qty_d = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			all_key_d = all_key_d | grp_key_s1[g];
			all_qty_d = all_qty_d | grp_qty_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_key_s1 <= grp_key_d;
		grp_qty_s1 <= grp_qty_d;
		rd_key_s2  <= all_key_d;
		rd_qty_s2  <= all_qty_d;
	end

	assign rd_key = rd_key_s2;
	assign rd_qty = signed'(rd_qty_s2);

endmodule

// File: rtl/sorted_table_insert_merge.sv
// Top level of the sorted key and quantity table: sequencer, binary search and the row of cells.
//
//  Channel   Ports                          Handshake
//  ------    -----------------------------  ------------------------------------------
//  input     start, busy, item (stim_in_t)  taken at a rising edge with start high, busy low
//  result    result_valid, result           one-cycle strobe per item, cannot be held off
//
// The path from acceptance to the result strobe depends on the operation: clear, load,
// out-of-range read and insert into an empty table finish in the dispatch state; a read of a
// valid entry passes through fetch, gather and finish; an insert of a new key or a full-table
// rejection ends with the binary search over the registered compare flags of the cells, and a
// merge into an existing key follows that search with fetch, gather and finish. The search loop
// and the two-stage gather tree that reads one cell set this timing. Reset empties the table at
// once; no clearing pass is needed. The block takes one item at a time: busy stays high from
// acceptance until the cycle in which the result is shown.
module sorted_table_insert_merge #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  stim_pkg::stim_in_t   item,
	output logic                 result_valid,
	output stim_pkg::stim_out_t  result
);
	import stim_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	stim_state_t state_q, state_d;

	stim_in_t             item_q;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [IDX_W-1:0]     lo_q, lo_d;
	logic [CNT_W-1:0]     hi_q, hi_d;
	logic [IDX_W-1:0]     target_q, target_d;
	logic                 res_valid_q, res_valid_d;
	stim_out_t            res_q, res_d;

	cell_cmd_t            cmd;
	logic [KEY_BITS-1:0]  bkey;
	logic signed [QTY_W-1:0] bqty;

	logic [KEY_BITS-1:0]     cell_key [CAPACITY];
	logic signed [QTY_W-1:0] cell_qty [CAPACITY];
	logic [CAPACITY-1:0]     cell_lt;
	logic [CAPACITY-1:0]     cell_eq;
	logic [KEY_BITS-1:0]     rd_key;
	logic signed [QTY_W-1:0] rd_qty;

	logic                 accept;
	logic                 full;
	logic                 idx_ok;
	logic                 narrow;
	logic [CNT_W:0]       mid_sum;
	logic [IDX_W-1:0]     mid;
	logic                 hit;
	logic                 found;
	logic [CNT_W-1:0]     ins_pos;
	logic signed [QTY_W:0] sum;
	logic signed [QTY_W-1:0] sat;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign bkey   = item_q.item_key[KEY_BITS-1:0];
	assign full   = (32'(count_q) >= CAPACITY);
	assign idx_ok = (32'(item_q.read_index) < 32'(count_q));

	// Search step: the last step looks at the low bound, others at the midpoint.
	assign narrow  = ((hi_q - CNT_W'(lo_q)) <= CNT_W'(1));
	assign mid_sum = (CNT_W+1)'(lo_q) + (CNT_W+1)'(hi_q);
	assign mid     = mid_sum[IDX_W:1];
	assign hit     = narrow ? cell_eq[lo_q] : cell_eq[mid];
	assign found   = hit;
	assign ins_pos = cell_lt[lo_q] ? CNT_W'(lo_q) + CNT_W'(1) : CNT_W'(lo_q);

	assign sum = (QTY_W+1)'(rd_qty) + (QTY_W+1)'(item_q.item_quantity);
	always_comb begin
		if (sum[QTY_W] != sum[QTY_W-1]) begin
			sat = sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
		end else begin
			sat = sum[QTY_W-1:0];
		end
	end

	assign bqty = (state_q == ST_FINISH) ? sat : item_q.item_quantity;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				if (item_q.operation == OP_INSERT && count_q != '0) state_d = ST_SEARCH;
				if (item_q.operation == OP_READ && idx_ok) state_d = ST_FETCH;
			end
			ST_SEARCH: begin
				if (found) begin
					state_d = ST_FETCH;
				end else if (narrow) begin
					state_d = ST_IDLE;
				end
			end
			ST_FETCH:  state_d = ST_GATHER;
			ST_GATHER: state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		count_d     = count_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		target_d    = target_q;
		res_valid_d = 1'b0;
		res_d       = res_q;
		cmd.op      = CELL_HOLD;
		cmd.pos     = '0;
		case (state_q)
			ST_DISPATCH: begin
				case (item_q.operation)
					OP_CLEAR: begin
						count_d     = '0;
						res_valid_d = 1'b1;
						res_d       = '0;
						res_d.status = STATUS_STORED;
					end
					OP_LOAD: begin
						res_valid_d          = 1'b1;
						res_d.entry_key      = OUT_KEY_W'(bkey);
						res_d.entry_quantity = item_q.item_quantity;
						if (full) begin
							res_d.entry_position = '0;
							res_d.entry_count    = CNT_OUT_W'(count_q);
							res_d.status         = STATUS_FULL;
						end else begin
							cmd.op               = CELL_WRITE;
							cmd.pos              = MAX_IDX_W'(count_q);
							count_d              = count_q + CNT_W'(1);
							res_d.entry_position = POS_OUT_W'(count_q);
							res_d.entry_count    = CNT_OUT_W'(count_d);
							res_d.status         = STATUS_STORED;
						end
					end
					OP_INSERT: begin
						if (count_q == '0) begin
							cmd.op               = CELL_SHIFT;
							cmd.pos              = '0;
							count_d              = CNT_W'(1);
							res_valid_d          = 1'b1;
							res_d.entry_key      = OUT_KEY_W'(bkey);
							res_d.entry_quantity = item_q.item_quantity;
							res_d.entry_position = '0;
							res_d.entry_count    = CNT_OUT_W'(count_d);
							res_d.status         = STATUS_STORED;
						end else begin
							cmd.op = CELL_CMP;
							lo_d   = '0;
							hi_d   = count_q;
						end
					end
					OP_READ: begin
						if (idx_ok) begin
							target_d = IDX_W'(item_q.read_index);
						end else begin
							res_valid_d          = 1'b1;
							res_d.entry_key      = '0;
							res_d.entry_quantity = '0;
							res_d.entry_position = item_q.read_index;
							res_d.entry_count    = CNT_OUT_W'(count_q);
							res_d.status         = STATUS_RANGE;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SEARCH: begin
				if (found) begin
					target_d = narrow ? lo_q : mid;
				end else if (narrow) begin
					res_valid_d          = 1'b1;
					res_d.entry_key      = OUT_KEY_W'(bkey);
					res_d.entry_quantity = item_q.item_quantity;
					if (full) begin
						res_d.entry_position = '0;
						res_d.entry_count    = CNT_OUT_W'(count_q);
						res_d.status         = STATUS_FULL;
					end else begin
						cmd.op               = CELL_SHIFT;
						cmd.pos              = MAX_IDX_W'(ins_pos);
						count_d              = count_q + CNT_W'(1);
						res_d.entry_position = POS_OUT_W'(ins_pos);
						res_d.entry_count    = CNT_OUT_W'(count_d);
						res_d.status         = STATUS_STORED;
					end
				end else if (cell_lt[mid]) begin
					lo_d = mid;
				end else begin
					hi_d = CNT_W'(mid);
				end
			end
			ST_FINISH: begin
				res_valid_d          = 1'b1;
				res_d.entry_key      = OUT_KEY_W'(rd_key);
				res_d.entry_position = POS_OUT_W'(target_q);
				res_d.entry_count    = CNT_OUT_W'(count_q);
				if (item_q.operation == OP_READ) begin
					res_d.entry_quantity = rd_qty;
					res_d.status         = STATUS_STORED;
				end else begin
					// The broadcast key equals the stored one, so only the quantity changes.
					cmd.op               = CELL_WRITE;
					cmd.pos              = MAX_IDX_W'(target_q);
					res_d.entry_quantity = sat;
					res_d.status         = STATUS_MERGED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		target_q <= target_d;
		res_q    <= res_d;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]     left_key;
		logic signed [QTY_W-1:0] left_qty;
		if (i == 0) begin : g_first
			assign left_key = bkey;
			assign left_qty = bqty;
		end else begin : g_rest
			assign left_key = cell_key[i-1];
			assign left_qty = cell_qty[i-1];
		end
		stim_cell #(
			.KEY_BITS (KEY_BITS),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.bcast_key (bkey),
			.bcast_qty (bqty),
			.left_key  (left_key),
			.left_qty  (left_qty),
			.key       (cell_key[i]),
			.qty       (cell_qty[i]),
			.lt        (cell_lt[i]),
			.eq        (cell_eq[i])
		);
	end

	stim_gather #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.IDX_W    (IDX_W)
	) u_gather (
		.clk      (clk),
		.cell_key (cell_key),
		.cell_qty (cell_qty),
		.target   (target_q),
		.rd_key   (rd_key),
		.rd_qty   (rd_qty)
	);

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (state_q == ST_IDLE))
		else $error("result shown while an item is still at work");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("entry count exceeds capacity");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (hi_q > CNT_W'(lo_q)) && (hi_q <= count_q))
		else $error("search bounds out of order");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !result_valid)
		else $error("accepted item did not hold the block busy");

	a_one_result_per_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> result_valid)
		else $error("gathered item gave no result");

endmodule

// File: dv/sorted_table_insert_merge_tb.sv
// Self-checking testbench for the sorted key and quantity table: directed rows, then random items.
module sorted_table_insert_merge_tb;
	import stim_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_W = 64;
	localparam logic [63:0] KEY_MSB = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic signed [31:0] QTY_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	stim_in_t  item;
	logic      result_valid;
	stim_out_t result;

	// Own copy of the table, advanced once per accepted item.
	logic [63:0]        tbl_keys [TABLE_DEPTH];
	logic signed [31:0] tbl_qtys [TABLE_DEPTH];
	int                 tbl_count = 0;

	stim_out_t awaited_entries [$];
	int        error_count = 0;
	int        gap_pct = 0;

	// A directed row may carry a result typed in by hand; it travels with the item.
	logic      typed_valid;
	stim_out_t typed_result;

	stim_in_t  dir_items [$];
	bit        dir_typed [$];
	stim_out_t dir_results [$];

	sorted_table_insert_merge #(
		.CAPACITY(TABLE_DEPTH),
		.KEY_BITS(KEY_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic stim_in_t mk_in(logic [1:0] op, logic [63:0] key, logic [31:0] qty,
		logic [5:0] idx);
		stim_in_t it;
		it.operation = op;
		it.item_key = key;
		it.item_quantity = qty;
		it.read_index = idx;
		return it;
	endfunction

	function automatic stim_out_t mk_out(logic [63:0] key, logic [31:0] qty, logic [5:0] pos,
		logic [6:0] cnt, logic [1:0] st);
		stim_out_t r;
		r.entry_key = key;
		r.entry_quantity = qty;
		r.entry_position = pos;
		r.entry_count = cnt;
		r.status = st;
		return r;
	endfunction

	// Applies one item to the table copy and returns the entry it touches.
	function automatic stim_out_t apply_to_table(stim_in_t it);
		stim_out_t res;
		int lo, hi, mid, pos, i;
		bit found;
		longint sum;
		res = '0;
		case (it.operation)
			OP_CLEAR: begin
				tbl_count = 0;
			end
			OP_LOAD: begin
				if (tbl_count >= TABLE_DEPTH) begin
					res.entry_key = it.item_key;
					res.entry_quantity = it.item_quantity;
					res.status = STATUS_FULL;
				end else begin
					tbl_keys[tbl_count] = it.item_key;
					tbl_qtys[tbl_count] = it.item_quantity;
					res.entry_key = it.item_key;
					res.entry_quantity = it.item_quantity;
					res.entry_position = tbl_count[5:0];
					res.status = STATUS_STORED;
					tbl_count++;
				end
			end
			OP_INSERT: begin
				pos = 0;
				found = 1'b0;
				if (tbl_count > 0) begin
					lo = 0;
					hi = tbl_count;
					while (hi - lo > 1 && !found) begin
						mid = (lo + hi) / 2;
						if (tbl_keys[mid] == it.item_key) begin
							found = 1'b1;
							pos = mid;
						end else if (tbl_keys[mid] < it.item_key) begin
							lo = mid;
						end else begin
							hi = mid;
						end
					end
					// The search narrowed to one entry without a hit in the middle.
					if (!found) begin
						found = (tbl_keys[lo] == it.item_key);
						pos = (tbl_keys[lo] < it.item_key) ? lo + 1 : lo;
					end
				end
				if (found) begin
					sum = longint'(tbl_qtys[pos]) + longint'(it.item_quantity);
					if (sum > longint'(QTY_MAX))
						sum = longint'(QTY_MAX);
					if (sum < longint'(QTY_MIN))
						sum = longint'(QTY_MIN);
					tbl_qtys[pos] = sum[31:0];
					res.entry_key = tbl_keys[pos];
					res.entry_quantity = tbl_qtys[pos];
					res.entry_position = pos[5:0];
					res.status = STATUS_MERGED;
				end else if (tbl_count >= TABLE_DEPTH) begin
					res.entry_key = it.item_key;
					res.entry_quantity = it.item_quantity;
					res.status = STATUS_FULL;
				end else begin
					for (i = tbl_count; i > pos; i--) begin
						tbl_keys[i] = tbl_keys[i-1];
						tbl_qtys[i] = tbl_qtys[i-1];
					end
					tbl_keys[pos] = it.item_key;
					tbl_qtys[pos] = it.item_quantity;
					tbl_count++;
					res.entry_key = it.item_key;
					res.entry_quantity = it.item_quantity;
					res.entry_position = pos[5:0];
					res.status = STATUS_STORED;
				end
			end
			default: begin
				res.entry_position = it.read_index;
				if (int'(it.read_index) < tbl_count) begin
					res.entry_key = tbl_keys[it.read_index];
					res.entry_quantity = tbl_qtys[it.read_index];
					res.status = STATUS_STORED;
				end else begin
					res.status = STATUS_RANGE;
				end
			end
		endcase
		res.entry_count = tbl_count[6:0];
		return res;
	endfunction

	function automatic void report_field(string name, logic [63:0] want, logic [63:0] got);
		error_count++;
		$display("%0t: %s expected %h got %h", $time, name, want, got);
	endfunction

	always @(posedge clk) begin
		stim_out_t head;
		if (arst_n) begin
			if (start && !busy) begin
				head = apply_to_table(item);
				awaited_entries = {awaited_entries, (typed_valid ? typed_result : head)};
			end
			if (result_valid) begin
				if (awaited_entries.size() == 0) begin
					report_field("unexpected result", '0, result.entry_key);
				end else begin
					head = awaited_entries.pop_front();
					if (result.entry_key !== head.entry_key)
						report_field("entry_key", head.entry_key, result.entry_key);
					if (result.entry_quantity !== head.entry_quantity)
						report_field("entry_quantity", 64'(head.entry_quantity),
							64'(result.entry_quantity));
					if (result.entry_position !== head.entry_position)
						report_field("entry_position", 64'(head.entry_position),
							64'(result.entry_position));
					if (result.entry_count !== head.entry_count)
						report_field("entry_count", 64'(head.entry_count),
							64'(result.entry_count));
					if (result.status !== head.status)
						report_field("status", 64'(head.status), 64'(result.status));
				end
			end
		end
	end

	function automatic stim_in_t noise_item();
		stim_in_t it;
		it.operation = 2'($urandom);
		it.item_key = {$urandom, $urandom};
		it.item_quantity = $urandom;
		it.read_index = 6'($urandom);
		return it;
	endfunction

	// Many keys hit the table or an extreme so that merges and saturation are frequent.
	function automatic stim_in_t random_item(bit fill_bias);
		stim_in_t it;
		int n, r;
		n = tbl_count;
		it = noise_item();
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: it.item_key = '0;
				1: it.item_key = KEY_ONES;
				2: it.item_key = KEY_MSB;
				default: it.item_key = 64'd1;
			endcase
		end else if (r < 45 && n > 0) begin
			it.item_key = tbl_keys[$urandom_range(0, n - 1)];
		end
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 3))
				0: it.item_quantity = QTY_MAX;
				1: it.item_quantity = QTY_MIN;
				2: it.item_quantity = -32'sd1;
				default: it.item_quantity = '0;
			endcase
		end
		if (n > 0 && $urandom_range(0, 99) < 70)
			it.read_index = 6'($urandom_range(0, n - 1));
		r = $urandom_range(0, 99);
		if (fill_bias)
			it.operation = (r < 60) ? OP_INSERT : (r < 90) ? OP_LOAD : OP_READ;
		else
			it.operation = (r < 2) ? OP_CLEAR : (r < 52) ? OP_INSERT : (r < 67) ? OP_LOAD : OP_READ;
		return it;
	endfunction

	task automatic hold_off(int cycles, bit drain);
		start <= 1'b0;
		typed_valid <= 1'b0;
		item <= noise_item();
		repeat (cycles) @(posedge clk);
		if (drain) begin
			do
				@(posedge clk);
			while (awaited_entries.size() != 0);
		end
	endtask

	task automatic issue_item(stim_in_t it, bit has_typed, stim_out_t typed);
		item <= it;
		start <= 1'b1;
		typed_valid <= has_typed;
		typed_result <= typed;
		@(posedge clk);
		while (busy) @(posedge clk);
		if ($urandom_range(0, 99) < gap_pct)
			hold_off($urandom_range(1, 6), 1'b0);
	endtask

	task automatic add_row(stim_in_t it, bit has_typed, stim_out_t typed);
		dir_items = {dir_items, it};
		dir_typed = {dir_typed, has_typed};
		dir_results = {dir_results, typed};
	endtask

	initial begin
		int sent, len, episode;
		stim_in_t it;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		typed_valid = 1'b0;
		typed_result = '0;

		add_row(mk_in(OP_READ, '0, '0, 6'd0), 1'b1, mk_out('0, '0, 6'd0, 7'd0, STATUS_RANGE));
		add_row(mk_in(OP_INSERT, KEY_MSB, QTY_MAX, 6'd0), 1'b1,
			mk_out(KEY_MSB, QTY_MAX, 6'd0, 7'd1, STATUS_STORED));
		add_row(mk_in(OP_INSERT, KEY_MSB, 32'sd1, 6'd0), 1'b1,
			mk_out(KEY_MSB, QTY_MAX, 6'd0, 7'd1, STATUS_MERGED));
		add_row(mk_in(OP_INSERT, '0, QTY_MIN, 6'd0), 1'b1,
			mk_out('0, QTY_MIN, 6'd0, 7'd2, STATUS_STORED));
		add_row(mk_in(OP_INSERT, '0, -32'sd1, 6'd0), 1'b1,
			mk_out('0, QTY_MIN, 6'd0, 7'd2, STATUS_MERGED));
		add_row(mk_in(OP_INSERT, KEY_ONES, 32'sd5, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_READ, '0, '0, 6'd63), 1'b1, mk_out('0, '0, 6'd63, 7'd3, STATUS_RANGE));
		add_row(mk_in(OP_READ, '0, '0, 6'd1), 1'b1,
			mk_out(KEY_MSB, QTY_MAX, 6'd1, 7'd3, STATUS_STORED));
		// Appending a small key behind the largest leaves the table out of order.
		add_row(mk_in(OP_LOAD, 64'd1, '0, 6'd0), 1'b1,
			mk_out(64'd1, '0, 6'd3, 7'd4, STATUS_STORED));
		add_row(mk_in(OP_INSERT, 64'd2, 32'sd3, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_INSERT, 64'd1, -32'sd5, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_READ, '0, '0, 6'd2), 1'b0, '0);
		add_row(mk_in(OP_INSERT, 64'h0123_4567_89ab_cdef, 32'sh5555_5555, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_INSERT, 64'hfedc_ba98_7654_3210, 32'shaaaa_aaaa, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_READ, '0, '0, 6'h2a), 1'b0, '0);
		add_row(mk_in(OP_READ, '0, '0, 6'h15), 1'b0, '0);
		add_row(mk_in(OP_CLEAR, KEY_ONES, -32'sd1, 6'd63), 1'b1,
			mk_out('0, '0, 6'd0, 7'd0, STATUS_STORED));
		add_row(mk_in(OP_READ, '0, '0, 6'd0), 1'b1, mk_out('0, '0, 6'd0, 7'd0, STATUS_RANGE));
		add_row(mk_in(OP_LOAD, KEY_ONES, QTY_MAX, 6'h3f), 1'b1,
			mk_out(KEY_ONES, QTY_MAX, 6'd0, 7'd1, STATUS_STORED));
		add_row(mk_in(OP_LOAD, '0, QTY_MIN, 6'd0), 1'b1,
			mk_out('0, QTY_MIN, 6'd1, 7'd2, STATUS_STORED));
		add_row(mk_in(OP_INSERT, KEY_ONES, -32'sd1, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_INSERT, '0, '0, 6'd0), 1'b0, '0);
		add_row(mk_in(OP_READ, '0, '0, 6'd0), 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 13;
		foreach (dir_items[i])
			issue_item(dir_items[i], dir_typed[i], dir_results[i]);
		hold_off(0, 1'b1);

		// Each episode starts from an empty table; the first one of a phase fills it up.
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 13 : (phase == 1) ? 86 : 0;
			sent = 0;
			episode = 0;
			while (sent < 270) begin
				if ($urandom_range(0, 99) < 30)
					hold_off(0, 1'b1);
				it = noise_item();
				it.operation = OP_CLEAR;
				issue_item(it, 1'b0, '0);
				len = (episode == 0) ? 140 : $urandom_range(10, 110);
				for (int j = 0; j < len; j++)
					issue_item(random_item(episode == 0), 1'b0, '0);
				sent += len + 1;
				episode++;
			end
		end

		hold_off(0, 1'b1);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
